### sv/sfid_pkg.sv
// Shared constants, codes and cell interface types for the smallest-first ID allocator.
package sfid_pkg;

   localparam int ID_W       = 16;
   localparam int FREE_DEPTH = 64;
   localparam int IDX_W      = $clog2(FREE_DEPTH);
   localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
   localparam int MARK_W     = ID_W + 1;

   typedef enum logic [1:0] {
      REQ_ALLOC       = 2'd0,
      REQ_RELEASE     = 2'd1,
      REQ_QUERY       = 2'd2,
      REQ_RELEASE_ALL = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_IGNORED   = 2'd1,
      ST_EXHAUSTED = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_TRIM,
      S_SEND
   } state_type;

   typedef struct packed {
      logic              capture;
      logic              shift_left;
      logic              insert;
      logic [ID_W-1:0]   id;
      logic [CNT_W-1:0]  count;
      logic [MARK_W-1:0] mark;
   } cell_cmd_type;

   typedef struct packed {
      logic lt;
      logic eq;
      logic match;
   } cell_flag_type;

endpackage

### sv/sfid_cell.sv
// One free-list cell: holds an entry, compares it against the probe ID and shifts with neighbors.
module sfid_cell
   import sfid_pkg::*;
(
   input  logic                clock,
   input  logic [IDX_W-1:0]    cell_idx,
   input  cell_cmd_type        cmd,
   input  logic [ID_W-1:0]     left_entry,
   input  logic                left_lt,
   input  logic [ID_W-1:0]     right_entry,
   output logic [ID_W-1:0]     entry,
   output cell_flag_type       flags
);

   logic [ID_W-1:0] entry_ff, entry_in;
   cell_flag_type   flags_ff, flags_in;
   logic            occupied;
   logic [MARK_W:0] trail_lhs;
   logic [MARK_W:0] trail_rhs;

   assign occupied = {1'b0, cell_idx} < cmd.count;

   // entry + count - idx + 1 == mark marks the trailing run contiguous with mark - 1
   assign trail_lhs = (MARK_W + 1)'(entry_ff) + (MARK_W + 1)'(cmd.count) + (MARK_W + 1)'(1);
   assign trail_rhs = (MARK_W + 1)'(cmd.mark) + (MARK_W + 1)'(cell_idx);

   always_comb begin
      flags_in.lt    = occupied && (entry_ff < cmd.id);
      flags_in.eq    = occupied && (entry_ff == cmd.id);
      flags_in.match = occupied && (trail_lhs == trail_rhs);
   end

   always_comb begin
      entry_in = entry_ff;
      if (cmd.shift_left) begin
         entry_in = right_entry;
      end else if (cmd.insert && !flags_ff.lt) begin
         entry_in = left_lt ? cmd.id : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmd.capture) begin
         flags_ff <= flags_in;
      end
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

### sv/smallest_first_id_allocator_unit.sv
// Top level of the smallest-first ID allocator: control sequencer, counters and the cell chain.
//
// Usage: an item on req_ (req_type, req_id_in) is taken when req_valid is high and
// req_stall is low. Allocate returns the smallest released ID, or the high-water mark
// when nothing is released; release, query and release-all act on the same state.
// Every item gives exactly one result item on rsp_, carrying the ID, the query answer,
// the mark and live count after the item, and a status code.
// Sequence: the cell chain registers its compare flags at the accepting edge, and S_EXEC
// updates the state and loads the result register; a release of the ID just below the
// mark that trims free IDs off the top of the list passes through S_TRIM, which drops
// the trimmed entries, up to 64, one at a time, and then S_SEND, which loads the result.
// req_stall is high while an item is in work. A result held by rsp_stall does not
// block the next item's acceptance; the following result waits in a hold stage until
// the output register is taken.
// Reset (synchronous, active high) empties the free list, zeroes mark and live count
// and drops any pending result. Free-list storage is not cleared; only entries below
// the fill count are ever used.
module smallest_first_id_allocator_unit
   import sfid_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [ID_W-1:0]   req_id_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ID_W-1:0]   rsp_id_out,
   output logic              rsp_is_live,
   output logic [MARK_W-1:0] rsp_mark_out,
   output logic [MARK_W-1:0] rsp_live_out,
   output logic [1:0]        rsp_status
);

   state_type         state_ff, state_in;
   req_code_type      op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [MARK_W-1:0] mark_ff, mark_in;
   logic [MARK_W-1:0] live_ff, live_in;

   logic [ID_W-1:0]   res_id_ff, res_id;
   logic              res_live_ff, res_live;
   status_type        res_status_ff, res_status;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff;
   logic              rsp_live_ff;
   logic [MARK_W-1:0] rsp_mark_ff;
   logic [MARK_W-1:0] rsp_cnt_ff;
   status_type        rsp_status_ff;

   cell_cmd_type      cmd;
   logic [ID_W-1:0]   entry_w [FREE_DEPTH];
   cell_flag_type     flag_w  [FREE_DEPTH];
   logic [FREE_DEPTH-1:0] eq_vec;
   logic [FREE_DEPTH-1:0] match_vec;

   logic              any_eq;
   logic              rsp_free;
   logic              need_trim;
   logic              trim_more;
   logic              load_exec;
   logic              load_send;
   logic [MARK_W-1:0] live_dec;
   logic [IDX_W-1:0]  last_idx;
   logic [IDX_W-1:0]  next_last_idx;

   genvar gi;
   generate
      for (gi = 0; gi < FREE_DEPTH; gi++) begin : g_cell
         logic [ID_W-1:0] left_entry;
         logic            left_lt;
         logic [ID_W-1:0] right_entry;

         if (gi == 0) begin : g_head
            assign left_entry = entry_w[gi];
            assign left_lt    = 1'b1;
         end else begin : g_body
            assign left_entry = entry_w[gi-1];
            assign left_lt    = flag_w[gi-1].lt;
         end

         if (gi == FREE_DEPTH - 1) begin : g_tail
            assign right_entry = entry_w[gi];
         end else begin : g_inner
            assign right_entry = entry_w[gi+1];
         end

         sfid_cell u_cell (
            .clock       (clock),
            .cell_idx    (IDX_W'(gi)),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .left_lt     (left_lt),
            .right_entry (right_entry),
            .entry       (entry_w[gi]),
            .flags       (flag_w[gi])
         );

         assign eq_vec[gi]    = flag_w[gi].eq;
         assign match_vec[gi] = flag_w[gi].match;
      end
   endgenerate

   assign any_eq        = |eq_vec;
   assign rsp_free      = !rsp_valid_ff || !rsp_stall;
   assign live_dec      = (live_ff != '0) ? live_ff - MARK_W'(1) : live_ff;
   assign last_idx      = count_ff[IDX_W-1:0] - IDX_W'(1);
   assign next_last_idx = count_ff[IDX_W-1:0] - IDX_W'(2);
   assign trim_more     = (count_ff > CNT_W'(1)) && match_vec[next_last_idx];

   // datapath and sequencer outputs
   always_comb begin
      count_in       = count_ff;
      mark_in        = mark_ff;
      live_in        = live_ff;
      res_id         = '0;
      res_live       = 1'b0;
      res_status     = ST_OK;
      need_trim      = 1'b0;
      cmd.capture    = 1'b0;
      cmd.shift_left = 1'b0;
      cmd.insert     = 1'b0;
      cmd.id         = id_ff;
      cmd.count      = count_ff;
      cmd.mark       = mark_ff;

      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            cmd.id      = req_id_in;
         end
         S_EXEC: begin
            unique case (op_ff)
               REQ_ALLOC: begin
                  if (count_ff != '0) begin
                     res_id         = entry_w[0];
                     cmd.shift_left = 1'b1;
                     count_in       = count_ff - CNT_W'(1);
                     live_in        = live_ff + MARK_W'(1);
                  end else if (!mark_ff[MARK_W-1]) begin
                     res_id  = mark_ff[ID_W-1:0];
                     mark_in = mark_ff + MARK_W'(1);
                     live_in = live_ff + MARK_W'(1);
                  end else begin
                     res_status = ST_EXHAUSTED;
                  end
               end
               REQ_RELEASE: begin
                  if (({1'b0, id_ff} >= mark_ff) || any_eq) begin
                     res_status = ST_IGNORED;
                  end else if ({1'b0, id_ff} == mark_ff - MARK_W'(1)) begin
                     mark_in   = mark_ff - MARK_W'(1);
                     live_in   = live_dec;
                     need_trim = (count_ff != '0) && match_vec[last_idx];
                  end else if (count_ff == CNT_W'(FREE_DEPTH)) begin
                     res_status = ST_FULL;
                  end else begin
                     cmd.insert = 1'b1;
                     count_in   = count_ff + CNT_W'(1);
                     live_in    = live_dec;
                  end
               end
               REQ_QUERY: begin
                  res_live = ({1'b0, id_ff} < mark_ff) && !any_eq;
               end
               REQ_RELEASE_ALL: begin
                  count_in = '0;
                  mark_in  = '0;
                  live_in  = '0;
               end
               default: begin
               end
            endcase
         end
         S_TRIM: begin
            count_in = count_ff - CNT_W'(1);
            mark_in  = mark_ff - MARK_W'(1);
         end
         S_SEND: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (need_trim) begin
               state_in = S_TRIM;
            end else if (rsp_free) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SEND;
            end
         end
         S_TRIM: begin
            if (!trim_more) begin
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign load_exec    = (state_ff == S_EXEC) && !need_trim && rsp_free;
   assign load_send    = (state_ff == S_SEND) && rsp_free;
   assign rsp_valid_in = load_exec || load_send || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mark_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mark_ff      <= mark_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         op_ff <= req_code_type'(req_type);
         id_ff <= req_id_in;
      end
      if (state_ff == S_EXEC) begin
         res_id_ff     <= res_id;
         res_live_ff   <= res_live;
         res_status_ff <= res_status;
      end
      if (load_exec) begin
         rsp_id_ff     <= res_id;
         rsp_live_ff   <= res_live;
         rsp_status_ff <= res_status;
         rsp_mark_ff   <= mark_in;
         rsp_cnt_ff    <= live_in;
      end else if (load_send) begin
         rsp_id_ff     <= res_id_ff;
         rsp_live_ff   <= res_live_ff;
         rsp_status_ff <= res_status_ff;
         rsp_mark_ff   <= mark_ff;
         rsp_cnt_ff    <= live_ff;
      end
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_id_out   = rsp_id_ff;
   assign rsp_is_live  = rsp_live_ff;
   assign rsp_mark_out = rsp_mark_ff;
   assign rsp_live_out = rsp_cnt_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

### bench/tb_smallest_first_id_allocator_unit.sv
// Self-checking testbench for the smallest-first ID allocator unit: random and directed items, scoreboard.
module tb_smallest_first_id_allocator_unit;
   import sfid_pkg::*;

   localparam int ID_SPACE    = 1 << ID_W;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 80;
   localparam int MAX_REPORTS = 20;

   typedef struct {
      logic [ID_W-1:0]   id;
      logic              live;
      logic [MARK_W-1:0] mark;
      logic [MARK_W-1:0] live_cnt;
      status_type        status;
   } alloc_result_type;

   class alloc_tracker;
      logic [MARK_W-1:0] mark;
      logic [MARK_W-1:0] live_cnt;
      logic [ID_W-1:0]   free_ids[$];
      alloc_result_type  expected[$];
      int                errors;

      function new();
         mark     = '0;
         live_cnt = '0;
         errors   = 0;
      endfunction

      function bit is_free(logic [ID_W-1:0] id);
         foreach (free_ids[i]) if (free_ids[i] == id) return 1;
         return 0;
      endfunction

      function void note_request(req_code_type op, logic [ID_W-1:0] id);
         alloc_result_type r;
         int pos;
         r.id     = '0;
         r.live   = 1'b0;
         r.status = ST_OK;
         case (op)
            REQ_ALLOC: begin
               if (free_ids.size() > 0) begin
                  r.id = free_ids.pop_front();
                  live_cnt++;
               end else if (mark < ID_SPACE) begin
                  r.id = mark[ID_W-1:0];
                  mark++;
                  live_cnt++;
               end else begin
                  r.status = ST_EXHAUSTED;
               end
            end
            REQ_RELEASE: begin
               if ({1'b0, id} >= mark || is_free(id)) begin
                  r.status = ST_IGNORED;
               end else if ({1'b0, id} == mark - 1) begin
                  mark--;
                  while (free_ids.size() > 0 && mark > 0 &&
                         {1'b0, free_ids[$]} == mark - 1) begin
                     void'(free_ids.pop_back());
                     mark--;
                  end
                  if (live_cnt > 0) live_cnt--;
               end else if (free_ids.size() >= FREE_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  pos = 0;
                  while (pos < free_ids.size() && free_ids[pos] < id) pos++;
                  free_ids.insert(pos, id);
                  if (live_cnt > 0) live_cnt--;
               end
            end
            REQ_QUERY: begin
               r.live = ({1'b0, id} < mark) && !is_free(id);
            end
            REQ_RELEASE_ALL: begin
               free_ids.delete();
               mark     = '0;
               live_cnt = '0;
            end
         endcase
         r.mark     = mark;
         r.live_cnt = live_cnt;
         expected.push_back(r);
      endfunction

      function void compare(string what, logic [MARK_W-1:0] exp_v, logic [MARK_W-1:0] act_v);
         if (act_v !== exp_v) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
         end
      endfunction

      function void check_result(logic [ID_W-1:0] id, logic live, logic [MARK_W-1:0] m,
                                 logic [MARK_W-1:0] lc, logic [1:0] st);
         alloc_result_type e;
         if (expected.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result item with nothing expected, id %0h mark %0h",
                        $time, id, m);
            return;
         end
         e = expected.pop_front();
         compare("id_out", e.id, id);
         compare("is_live", e.live, live);
         compare("mark_out", e.mark, m);
         compare("live_out", e.live_cnt, lc);
         compare("status", e.status, st);
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_type;
   logic [ID_W-1:0]   req_id_in;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [ID_W-1:0]   rsp_id_out;
   logic              rsp_is_live;
   logic [MARK_W-1:0] rsp_mark_out;
   logic [MARK_W-1:0] rsp_live_out;
   logic [1:0]        rsp_status;

   alloc_tracker book = new();
   int send_idle_pct;
   int stall_pct;
   int items_sent = 0;
   int quiet = 0;

   smallest_first_id_allocator_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_id_in    (req_id_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_id_out   (rsp_id_out),
      .rsp_is_live  (rsp_is_live),
      .rsp_mark_out (rsp_mark_out),
      .rsp_live_out (rsp_live_out),
      .rsp_status   (rsp_status)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_result(rsp_id_out, rsp_is_live, rsp_mark_out, rsp_live_out, rsp_status);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet = 0;
      else
         quiet = quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
         $display("** smallest_first_id_allocator_unit: FAILED **");
         $finish;
      end
   end

   task automatic send_item(req_code_type op, logic [ID_W-1:0] id);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= op;
      req_id_in <= id;
      do @(posedge clock); while (req_stall);
      book.note_request(op, id);
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // live ID below the mark; below_top skips the ID just under the mark
   function automatic bit pick_live(bit below_top, output logic [ID_W-1:0] id);
      int top;
      int start;
      id  = '0;
      top = int'(book.mark) - (below_top ? 2 : 1);
      if (top < 0) return 0;
      start = $urandom_range(top, 0);
      for (int k = 0; k <= top; k++) begin
         id = ID_W'((start + k) % (top + 1));
         if (!book.is_free(id)) return 1;
      end
      return 0;
   endfunction

   function automatic logic [ID_W-1:0] rand_id();
      return ID_W'($urandom);
   endfunction

   task automatic fill_free_list();
      logic [ID_W-1:0] id;
      while (book.mark < FREE_DEPTH + 8) send_item(REQ_ALLOC, rand_id());
      while (book.free_ids.size() < FREE_DEPTH && pick_live(1, id))
         send_item(REQ_RELEASE, id);
      if (pick_live(1, id)) send_item(REQ_RELEASE, id);
   endtask

   task automatic run_random(int n);
      int stop;
      int choice;
      int runs;
      logic [ID_W-1:0] id;
      stop = items_sent + n;
      while (items_sent < stop) begin
         choice = $urandom_range(99);
         if (choice < 30) begin
            runs = $urandom_range(8, 1);
            repeat (runs) send_item(REQ_ALLOC, rand_id());
         end else if (choice < 55) begin
            runs = $urandom_range(6, 1);
            repeat (runs) if (pick_live(1, id)) send_item(REQ_RELEASE, id);
         end else if (choice < 65) begin
            if (book.mark > 0) send_item(REQ_RELEASE, ID_W'(book.mark - 1));
         end else if (choice < 80) begin
            case ($urandom_range(2))
               0: if (pick_live(0, id)) send_item(REQ_QUERY, id);
               1: if (book.free_ids.size() > 0)
                     send_item(REQ_QUERY,
                               book.free_ids[$urandom_range(book.free_ids.size() - 1)]);
               default: send_item(REQ_QUERY, rand_id());
            endcase
         end else if (choice < 88) begin
            case ($urandom_range(2))
               0: send_item(REQ_RELEASE, rand_id());
               1: if (book.free_ids.size() > 0)
                     send_item(REQ_RELEASE,
                               book.free_ids[$urandom_range(book.free_ids.size() - 1)]);
               default: if (book.mark < ID_SPACE)
                           send_item(REQ_RELEASE, book.mark[ID_W-1:0]);
            endcase
         end else if (choice < 89) begin
            fill_free_list();
         end else if (choice < 91) begin
            send_item(REQ_RELEASE_ALL, rand_id());
         end else begin
            send_item(REQ_ALLOC, rand_id());
         end
      end
   endtask

   task automatic run_directed();
      send_item(REQ_QUERY, 0);
      send_item(REQ_RELEASE, 0);
      send_item(REQ_RELEASE_ALL, '1);
      repeat (5) send_item(REQ_ALLOC, '1);
      send_item(REQ_QUERY, 2);
      send_item(REQ_QUERY, '1);
      send_item(REQ_RELEASE, 1);
      send_item(REQ_RELEASE, 1);
      send_item(REQ_RELEASE, 3);
      send_item(REQ_RELEASE, 4);
      send_item(REQ_QUERY, 1);
      send_item(REQ_ALLOC, 0);
      send_item(REQ_RELEASE, 2);
      send_item(REQ_RELEASE, '1);
      send_item(REQ_RELEASE, 0);
      send_item(REQ_RELEASE, 1);
      send_item(REQ_ALLOC, 0);
      send_item(REQ_ALLOC, 0);
      send_item(REQ_RELEASE_ALL, 0);
      send_item(REQ_QUERY, 0);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = REQ_ALLOC;
      req_id_in     = '0;
      rsp_stall     = 1'b0;
      send_idle_pct = 38;
      stall_pct     = 56;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(100);

      send_idle_pct = 56;
      stall_pct     = 38;
      fill_free_list();
      run_random(100);
      drain();

      send_idle_pct = 0;
      stall_pct     = 0;
      run_random(100);
      drain();

      if (book.errors == 0)
         $display("** smallest_first_id_allocator_unit: PASSED **");
      else
         $display("** smallest_first_id_allocator_unit: FAILED **");
      $finish;
   end

endmodule
